/* hdl/tha_pkg.sv */
// Shared types and constants of the timing histogram accumulator.
// Used by tha_front, tha_queue, tha_back and the top level; no dependencies.
`default_nettype none

package tha_pkg;

    // Stream layout
    localparam int CMD_W      = 2;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 2;

    // Command codes carried on s_tuser
    localparam logic [CMD_W-1:0] CMD_RECORD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ_TIME = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_RF   = 2'd2;

    // Job fields, sized for the largest parameter set
    localparam int SLOT_W = 8;   // up to 32 positions x 8 cores
    localparam int TBIN_W = 16;  // up to 65536 time bins
    localparam int RBIN_W = 14;  // up to 16384 rf bins

    // Time arithmetic in sixteenths
    localparam int SUM_W = 30;
    localparam int Q_W   = SUM_W - 4;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_RECORD,
        JOB_READ_TIME,
        JOB_READ_RF
    } job_kind_t;

    typedef struct packed {
        job_kind_t         kind;
        logic [SLOT_W-1:0] slot;
        logic [TBIN_W-1:0] t_bin;
        logic [RBIN_W-1:0] r_bin;
        logic              rf_hit;
    } tha_job_t;

endpackage

`default_nettype wire

/* hdl/tha_front.sv */
// Front end: accepts stream words, qualifies hits and computes the histogram bins.
// Depends on tha_pkg.
`default_nettype none

module tha_front #(
    parameter int POSITIONS = 16,
    parameter int CORES     = 4,
    parameter int TIME_BINS = 32768,
    parameter int RF_BINS   = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tha_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [tha_pkg::CMD_W-1:0]     s_tuser,
    input  logic                          clear_busy,
    output logic                          push_valid,
    input  logic                          push_ready,
    output tha_pkg::tha_job_t             push_job
);
    import tha_pkg::*;

    localparam logic [5:0]        POS_LIM   = 6'(POSITIONS);
    localparam logic [3:0]        CORE_LIM  = 4'(CORES);
    localparam logic [16:0]       TBIN_LIM  = 17'(TIME_BINS);
    localparam logic [14:0]       RBIN_LIM  = 15'(RF_BINS);
    localparam logic [SUM_W-1:0]  TIME_OFS  = SUM_W'(TIME_BINS * 8);
    localparam logic [TBIN_W-1:0] BIN_UNDER = TBIN_W'(TIME_BINS - 1000);
    localparam logic [TBIN_W-1:0] BIN_OVER  = TBIN_W'(TIME_BINS - 2000);
    localparam logic [Q_W-2:0]    Q_LIM     = (Q_W - 1)'(TIME_BINS);

    // Input fields
    logic [4:0]  pos;
    logic [1:0]  core;
    logic [2:0]  folds;
    logic [15:0] arr_pat;
    logic [3:0]  core_pat;
    logic        thit;
    logic [23:0] cfd;
    logic [19:0] ts;
    logic        rf_on;
    logic [15:0] rf;
    logic [14:0] rbin;

    logic              s_fire;
    logic              push_fire;
    logic [4:0]        pos_m1;
    logic              addr_ok;
    logic              hit_ok;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       rf_units;
    logic [SUM_W-1:0]  sum;
    job_kind_t         kind;

    // Classified word
    logic              f_valid_reg;
    job_kind_t         kind_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              rf_on_reg;
    logic [15:0]       rf_reg;
    logic [14:0]       rbin_reg;

    // Rounding and clamping
    logic [Q_W-1:0]    q;
    logic              t_up;
    logic [Q_W-1:0]    q_rnd;
    logic [TBIN_W-1:0] bin;
    logic              r_up;
    logic [12:0]       rb;
    logic              rf_hit;

    assign pos      = s_tdata[4:0];
    assign core     = s_tdata[6:5];
    assign folds    = s_tdata[9:7];
    assign arr_pat  = s_tdata[25:10];
    assign core_pat = s_tdata[29:26];
    assign thit     = s_tdata[30];
    assign cfd      = s_tdata[54:31];
    assign ts       = s_tdata[74:55];
    assign rf_on    = s_tdata[75];
    assign rf       = s_tdata[91:76];
    assign rbin     = s_tdata[106:92];

    assign push_fire  = f_valid_reg && push_ready;
    assign push_valid = f_valid_reg;
    assign s_tready   = !clear_busy && (!f_valid_reg || push_ready);
    assign s_fire     = s_tvalid && s_tready;

    always_comb
    begin
        pos_m1   = pos - 5'd1;
        addr_ok  = (pos != 5'd0) && ({1'b0, pos} <= POS_LIM) && ({2'b00, core} < CORE_LIM);
        hit_ok   = (folds == 3'b111) && thit && !pos_m1[4] && arr_pat[pos_m1[3:0]]
                   && core_pat[core];
        slot     = SLOT_W'(pos_m1) * SLOT_W'(CORES) + SLOT_W'(core);
        rf_units = rf_on ? rf : 16'd0;
        // cfd - 16*ts - rf + TIME_BINS/2, in sixteenths, two's complement
        sum      = SUM_W'({cfd, 4'b0000}) - SUM_W'({ts, 8'h00}) - SUM_W'(rf_units)
                   + TIME_OFS;
        case (s_tuser)
            CMD_RECORD:    kind = (addr_ok && hit_ok) ? JOB_RECORD : JOB_NONE;
            CMD_READ_TIME: kind = (addr_ok && ({2'b00, rbin} < TBIN_LIM)) ?
                                  JOB_READ_TIME : JOB_NONE;
            CMD_READ_RF:   kind = (addr_ok && (rbin < RBIN_LIM)) ? JOB_READ_RF : JOB_NONE;
            default:       kind = JOB_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            f_valid_reg <= 1'b1;
        end
        else if (push_fire)
        begin
            f_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            kind_reg  <= kind;
            slot_reg  <= slot;
            sum_reg   <= sum;
            rf_on_reg <= rf_on;
            rf_reg    <= rf;
            rbin_reg  <= rbin;
        end
    end

    // Round half to even, then fold out-of-range bins onto their markers
    always_comb
    begin
        q     = sum_reg[SUM_W-1:4];
        t_up  = (sum_reg[3:0] > 4'd8) || ((sum_reg[3:0] == 4'd8) && q[0]);
        q_rnd = q + Q_W'(t_up);
        if (q_rnd[Q_W-1])
        begin
            bin = BIN_UNDER;
        end
        else if (q_rnd[Q_W-2:0] >= Q_LIM)
        begin
            bin = BIN_OVER;
        end
        else
        begin
            bin = q_rnd[TBIN_W-1:0];
        end
        r_up   = (rf_reg[3:0] > 4'd8) || ((rf_reg[3:0] == 4'd8) && rf_reg[4]);
        rb     = {1'b0, rf_reg[15:4]} + 13'(r_up);
        rf_hit = rf_on_reg && (15'(rb) < RBIN_LIM);

        push_job.kind   = kind_reg;
        push_job.slot   = slot_reg;
        push_job.t_bin  = (kind_reg == JOB_RECORD) ? bin : TBIN_W'(rbin_reg);
        push_job.r_bin  = (kind_reg == JOB_RECORD) ? RBIN_W'(rb) : RBIN_W'(rbin_reg);
        push_job.rf_hit = (kind_reg == JOB_RECORD) && rf_hit;
    end

endmodule

`default_nettype wire

/* hdl/tha_queue.sv */
// Two-entry job queue between the front end and the histogram back end.
// Depends on tha_pkg.
`default_nettype none

module tha_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  tha_pkg::tha_job_t push_job,
    output logic              pop_valid,
    input  logic              pop_ready,
    output tha_pkg::tha_job_t pop_job
);
    import tha_pkg::*;

    tha_job_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push_fire;
    logic       pop_fire;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push_fire && !pop_fire)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop_fire && !push_fire)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

/* hdl/tha_back.sv */
// Back end: holds both histogram memories, clears them after reset and runs
// one read-modify-write or read per job other than JOB_NONE. Depends on tha_pkg.
`default_nettype none

module tha_back #(
    parameter int POSITIONS   = 16,
    parameter int CORES       = 4,
    parameter int TIME_BINS   = 32768,
    parameter int RF_BINS     = 4096,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  tha_pkg::tha_job_t              pop_job,
    output logic                           clear_busy,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tha_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [tha_pkg::OUT_USER_W-1:0] m_tuser
);
    import tha_pkg::*;

    localparam int SLOTS     = POSITIONS * CORES;
    localparam int T_DEPTH   = SLOTS * TIME_BINS;
    localparam int R_DEPTH   = SLOTS * RF_BINS;
    localparam int T_AW      = $clog2(T_DEPTH);
    localparam int R_AW      = $clog2(R_DEPTH);
    localparam int CLR_DEPTH = (T_DEPTH > R_DEPTH) ? T_DEPTH : R_DEPTH;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);
    localparam logic [CLR_AW:0]   T_LIM    = (CLR_AW + 1)'(T_DEPTH);
    localparam logic [CLR_AW:0]   R_LIM    = (CLR_AW + 1)'(R_DEPTH);
    localparam logic [CLR_AW-1:0] CLR_LAST = CLR_AW'(CLR_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

    logic [COUNT_WIDTH-1:0] t_mem [T_DEPTH];
    logic [COUNT_WIDTH-1:0] r_mem [R_DEPTH];

    state_t                 state_reg;
    logic [CLR_AW-1:0]      clr_reg;
    tha_job_t               job_reg;
    logic [T_AW-1:0]        t_addr_reg;
    logic [R_AW-1:0]        r_addr_reg;
    logic [COUNT_WIDTH-1:0] t_rdata_reg;
    logic [COUNT_WIDTH-1:0] r_rdata_reg;

    logic                   out_valid_reg;
    logic                   accepted_reg;
    logic [14:0]            time_bin_reg;
    logic                   rf_rec_reg;
    logic [11:0]            rf_bin_reg;
    logic [31:0]            count_reg;

    logic                   pop_fire;
    logic [T_AW-1:0]        pop_t_addr;
    logic [R_AW-1:0]        pop_r_addr;
    logic                   t_re;
    logic                   r_re;
    logic                   t_we;
    logic                   r_we;
    logic [T_AW-1:0]        t_waddr;
    logic [R_AW-1:0]        r_waddr;
    logic [COUNT_WIDTH-1:0] t_wdata;
    logic [COUNT_WIDTH-1:0] r_wdata;
    logic [63:0]            t_wide;
    logic [63:0]            r_wide;
    logic [31:0]            count_next;
    logic                   is_record;

    assign clear_busy = (state_reg == ST_CLEAR);
    assign pop_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_t_addr = T_AW'(pop_job.slot) * T_AW'(TIME_BINS) + T_AW'(pop_job.t_bin);
    assign pop_r_addr = R_AW'(pop_job.slot) * R_AW'(RF_BINS) + R_AW'(pop_job.r_bin);
    assign t_re = pop_fire && ((pop_job.kind == JOB_RECORD) || (pop_job.kind == JOB_READ_TIME));
    assign r_re = pop_fire && ((pop_job.kind == JOB_READ_RF)
                  || ((pop_job.kind == JOB_RECORD) && pop_job.rf_hit));
    assign is_record = (job_reg.kind == JOB_RECORD);

    // Write port: zero sweep after reset, else increment of the counted cells
    always_comb
    begin
        t_we    = 1'b0;
        r_we    = 1'b0;
        t_waddr = t_addr_reg;
        r_waddr = r_addr_reg;
        t_wdata = t_rdata_reg + COUNT_WIDTH'(1);
        r_wdata = r_rdata_reg + COUNT_WIDTH'(1);
        case (state_reg)
            ST_CLEAR:
            begin
                t_we    = ({1'b0, clr_reg} < T_LIM);
                r_we    = ({1'b0, clr_reg} < R_LIM);
                t_waddr = clr_reg[T_AW-1:0];
                r_waddr = clr_reg[R_AW-1:0];
                t_wdata = '0;
                r_wdata = '0;
            end
            ST_UPDATE:
            begin
                t_we = is_record;
                r_we = is_record && job_reg.rf_hit;
            end
            default:
            begin
                t_we = 1'b0;
                r_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            t_mem[t_waddr] <= t_wdata;
        end
        if (t_re)
        begin
            t_rdata_reg <= t_mem[pop_t_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_we)
        begin
            r_mem[r_waddr] <= r_wdata;
        end
        if (r_re)
        begin
            r_rdata_reg <= r_mem[pop_r_addr];
        end
    end

    always_comb
    begin
        t_wide = 64'(t_rdata_reg);
        r_wide = 64'(r_rdata_reg);
        case (job_reg.kind)
            JOB_READ_TIME: count_next = t_wide[31:0];
            JOB_READ_RF:   count_next = r_wide[31:0];
            default:       count_next = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            job_reg       <= '0;
            t_addr_reg    <= '0;
            r_addr_reg    <= '0;
            out_valid_reg <= 1'b0;
            accepted_reg  <= 1'b0;
            time_bin_reg  <= '0;
            rf_rec_reg    <= 1'b0;
            rf_bin_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (m_tready && (state_reg != ST_UPDATE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + CLR_AW'(1);
                    if (clr_reg == CLR_LAST)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (pop_fire)
                    begin
                        job_reg    <= pop_job;
                        t_addr_reg <= pop_t_addr;
                        r_addr_reg <= pop_r_addr;
                        state_reg  <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    // output slot was freed when this job was popped
                    out_valid_reg <= 1'b1;
                    accepted_reg  <= is_record;
                    time_bin_reg  <= is_record ? job_reg.t_bin[14:0] : 15'd0;
                    rf_rec_reg    <= is_record && job_reg.rf_hit;
                    rf_bin_reg    <= (is_record && job_reg.rf_hit) ? job_reg.r_bin[11:0] : 12'd0;
                    count_reg     <= count_next;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, count_reg, rf_bin_reg, time_bin_reg};
    assign m_tuser  = {rf_rec_reg, accepted_reg};

endmodule

`default_nettype wire

/* hdl/timing_histogram_accumulator.sv */
// Top level of the timing histogram accumulator: front end, job queue, back end.
// Depends on tha_pkg, tha_front, tha_queue and tha_back.
`default_nettype none

// Time-difference histogram per detector position and core. Each slave word is
// either a hit record or a read of one counter, selected by s_tuser. A hit that
// passes the fold, position, core and time qualifiers increments the time cell
// round(cfd - 16*ts - rf + TIME_BINS/2) of its (position, core) histogram, half
// to even; bins below zero land on TIME_BINS-1000 and bins at or past TIME_BINS
// on TIME_BINS-2000. With rf present it also increments rf cell round(rf) unless
// that is RF_BINS or more. Every slave word yields exactly one master word.
// After reset both memories are swept to zero, one address per cycle, over
// max(POSITIONS*CORES*TIME_BINS, POSITIONS*CORES*RF_BINS) cells (2097152 with
// the defaults); s_tready stays low during the sweep. Afterwards the front end
// takes a word per cycle while its queue has room; the back end reads memory
// for a word, then writes back and registers the result, and takes no new word
// until done. A word passes the front register, the queue and the back end's
// job register before the output register raises m_tvalid. While the master
// side stalls, the front keeps accepting until the queue and its register fill.

module timing_histogram_accumulator #(
    parameter int POSITIONS   = 16,
    parameter int CORES       = 4,
    parameter int TIME_BINS   = 32768,
    parameter int RF_BINS     = 4096,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // position[4:0] core[6:5] fold_flags[9:7] array_hit_pattern[25:10]
    // core_hit_pattern[29:26] time_hit_bit[30] cfd_time[54:31]
    // timestamp_low[74:55] rf_present[75] rf_time[91:76] read_bin[106:92], zero pad
    input  logic [tha_pkg::IN_DATA_W-1:0]  s_tdata,
    // command[1:0]
    input  logic [tha_pkg::CMD_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // time_bin[14:0] rf_bin[26:15] count_value[58:27], zero pad
    output logic [tha_pkg::OUT_DATA_W-1:0] m_tdata,
    // accepted[0] rf_recorded[1]
    output logic [tha_pkg::OUT_USER_W-1:0] m_tuser
);
    import tha_pkg::*;

    logic     clear_busy;
    logic     push_valid;
    logic     push_ready;
    tha_job_t push_job;
    logic     pop_valid;
    logic     pop_ready;
    tha_job_t pop_job;

    // Qualify the word and compute its bins
    tha_front #(
        .POSITIONS (POSITIONS),
        .CORES     (CORES),
        .TIME_BINS (TIME_BINS),
        .RF_BINS   (RF_BINS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .clear_busy (clear_busy),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // Decouple front and back so each stalls on its own
    tha_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Update or read the histogram memories and hold the result
    tha_back #(
        .POSITIONS   (POSITIONS),
        .CORES       (CORES),
        .TIME_BINS   (TIME_BINS),
        .RF_BINS     (RF_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire
